// ----- rtl/ucc_pkg.sv -----
// ----------------------------------------------------------------------------
// ucc_pkg
// Shared types, constants and a helper function for the UTF-8 code point
// counter.
// ----------------------------------------------------------------------------
package ucc_pkg;

    // Field widths of the transaction payloads
    localparam int BYTE_W       = 8;
    localparam int CHAR_COUNT_W = 16;
    localparam int CP_W         = 21;
    localparam int PEND_W       = 2;

    // Lead byte class boundaries
    localparam logic [BYTE_W-1:0] ASCII_END     = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_FIRST   = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD3_FIRST   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_FIRST   = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_BAD_FROM = 8'hF5;
    localparam logic [BYTE_W-1:0] CONT_MASK     = 8'h3F;

    // Rejected code point ranges
    localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO       = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI       = 21'h00DFFF;
    localparam logic [CP_W-1:0] NONCHAR_LO    = 21'h00FDD0;
    localparam logic [CP_W-1:0] NONCHAR_HI    = 21'h00FDEF;
    localparam logic [CP_W-1:0] NONCHAR_FFFE  = 21'h00FFFE;
    localparam logic [CP_W-1:0] NONCHAR_FFFF  = 21'h00FFFF;

    // Continuation counts loaded by a lead byte
    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    // One end-of-string result
    typedef struct packed {
        logic [CHAR_COUNT_W-1:0] char_count;
        logic                    string_valid;
    } t_result;

    // True when a decoded code point is allowed
    function automatic logic cp_acceptable(input logic [CP_W-1:0] cp);
        logic ok;
        ok = 1'b1;
        if (cp > CP_MAX) ok = 1'b0;
        if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
        if (cp >= NONCHAR_LO && cp <= NONCHAR_HI) ok = 1'b0;
        if (cp == NONCHAR_FFFE || cp == NONCHAR_FFFF) ok = 1'b0;
        return ok;
    endfunction

endpackage

// ----- rtl/ucc_if.sv -----
// ----------------------------------------------------------------------------
// ucc_text_if / ucc_result_if
// Valid/ready channels for the input bytes and the per-string results.
// ----------------------------------------------------------------------------
interface ucc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_string;

    modport source (output valid, output text_byte, output end_of_string, input ready);
    modport sink   (input valid, input text_byte, input end_of_string, output ready);
endinterface

interface ucc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_count;
    logic        string_valid;

    modport source (output valid, output char_count, output string_valid, input ready);
    modport sink   (input valid, input char_count, input string_valid, output ready);
endinterface

// ----- rtl/ucc_decode.sv -----
// ----------------------------------------------------------------------------
// ucc_decode
// Per-byte UTF-8 decoder: keeps the sequence state and the running count,
// and forms the end-of-string result for the byte being retired.
// ----------------------------------------------------------------------------
module ucc_decode #(
    parameter int COUNT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output ucc_pkg::t_result o_res
);
    import ucc_pkg::*;

    logic [PEND_W-1:0]     r_pend, n_pend;
    logic [CP_W-1:0]       r_acc,  n_acc;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_err,  n_err;

    logic [CP_W-1:0]       s_cp;
    logic                  s_cp_done;
    logic                  s_ok;

    // Next sequence state for the current byte
    always_comb begin
        n_pend    = r_pend;
        n_acc     = r_acc;
        n_count   = r_count;
        n_err     = r_err;
        s_cp      = {{(CP_W-BYTE_W){1'b0}}, i_byte};
        s_cp_done = 1'b0;
        if (!r_err) begin
            if (r_pend != PEND_NONE) begin
                n_acc     = {r_acc[CP_W-7:0], i_byte[5:0]};
                n_pend    = r_pend - PEND_ONE;
                s_cp      = n_acc;
                s_cp_done = (r_pend == PEND_ONE);
            end else if (i_byte < ASCII_END) begin
                s_cp_done = 1'b1;
            end else if (i_byte < LEAD2_FIRST || i_byte >= LEAD_BAD_FROM) begin
                n_err = 1'b1;
            end else if (i_byte < LEAD3_FIRST) begin
                n_acc  = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                n_pend = PEND_ONE;
            end else if (i_byte < LEAD4_FIRST) begin
                n_acc  = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                n_pend = PEND_TWO;
            end else begin
                n_acc  = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                n_pend = PEND_THREE;
            end
        end
        // Count a finished code point, saturating
        if (s_cp_done) begin
            if (!cp_acceptable(s_cp)) begin
                n_err = 1'b1;
            end else if (r_count != {COUNT_BITS{1'b1}}) begin
                n_count = r_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
        end
    end

    // Result for a final byte
    assign s_ok = !n_err && (n_pend == PEND_NONE);
    assign o_res.string_valid = s_ok;
    assign o_res.char_count   = s_ok ? CHAR_COUNT_W'(n_count) : '0;

    // State registers, cleared after each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= PEND_NONE;
            r_acc   <= '0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_pend  <= PEND_NONE;
                r_acc   <= '0;
                r_count <= '0;
                r_err   <= 1'b0;
            end else begin
                r_pend  <= n_pend;
                r_acc   <= n_acc;
                r_count <= n_count;
                r_err   <= n_err;
            end
        end
    end

endmodule

// ----- rtl/utf8_codepoint_counter.sv -----
// ----------------------------------------------------------------------------
// utf8_codepoint_counter
// UTF-8 string validator and code point counter with valid/ready channels.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless stalled: each accepted byte is held in an
// input register, is decoded against the sequence state in the same cycle
// it leaves that register, and a final byte writes one result into the
// output register, from which the result is presented. Input flow stops
// only when a final byte waits in the input register while the output
// register still holds an untaken result. The count saturates at
// 2^COUNT_BITS-1 and is reported as its low 16 bits; an invalid string
// reports count 0.
module utf8_codepoint_counter #(
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ucc_text_if.sink            i_text,
    ucc_result_if.source        o_result
);
    import ucc_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    t_result           s_res;
    logic              s_out_free;
    logic              s_adv;

    // Decode stage retires the held byte; a final byte only when the output side has room
    assign s_out_free    = !r_out_valid || o_result.ready;
    assign s_adv         = r_in_valid && (!r_in_last || s_out_free);
    assign i_text.ready  = !r_in_valid || s_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.end_of_string;
        end
    end

    ucc_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s_adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (s_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= s_adv && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && r_in_last) begin
            r_out <= s_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.char_count   = r_out.char_count;
    assign o_result.string_valid = r_out.string_valid;

    // A retired final byte always lands in the result register
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && r_in_last |=> r_out_valid)
        else $error("final byte retired without a result");

    // Invalid strings report a zero count
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.string_valid |-> r_out.char_count == '0)
        else $error("invalid string with nonzero count");

    // An empty input register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_text.ready)
        else $error("input stalled with empty input register");

endmodule

// ----- sim/ucc_checker.sv -----
// ----------------------------------------------------------------------------
// ucc_checker
// Watches both channels of the UTF-8 code point counter. It decodes every
// accepted byte with its own copy of the sequence state, queues the result
// each final byte should produce, and compares every accepted result with
// the oldest queued one.
// ----------------------------------------------------------------------------
module ucc_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ucc_text_if          i_text,
    ucc_result_if        i_result,
    output int           o_fail_count,
    output int           o_outstanding
);
    import ucc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Decoder state for the string in flight
    logic [PEND_W-1:0]     conts_left;
    logic [CP_W-1:0]       cp_acc;
    logic [COUNT_BITS-1:0] chars_seen;
    logic                  string_broken;

    t_result string_results_due[$];
    int      fail_count;

    function automatic void clear_string_state();
        conts_left    = PEND_NONE;
        cp_acc        = '0;
        chars_seen    = '0;
        string_broken = 1'b0;
    endfunction

    // Surrogates, the FDD0-FDEF block, FFFE/FFFF and anything past 10FFFF
    // are not allowed
    function automatic logic code_point_allowed(input logic [CP_W-1:0] cp);
        return !((cp > CP_MAX)
                 || (cp >= SURR_LO && cp <= SURR_HI)
                 || (cp >= NONCHAR_LO && cp <= NONCHAR_HI)
                 || (cp == NONCHAR_FFFE) || (cp == NONCHAR_FFFF));
    endfunction

    function automatic void tally_code_point(input logic [CP_W-1:0] cp);
        if (!code_point_allowed(cp)) begin
            string_broken = 1'b1;
        end else if (chars_seen != {COUNT_BITS{1'b1}}) begin
            chars_seen = chars_seen + COUNT_BITS'(1);
        end
    endfunction

    // Advance the decoder by one byte; a final byte queues one result
    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_result due;
        logic    ok;
        if (!string_broken) begin
            if (conts_left != PEND_NONE) begin
                cp_acc     = {cp_acc[CP_W-7:0], b[5:0]};
                conts_left = conts_left - PEND_ONE;
                if (conts_left == PEND_NONE) tally_code_point(cp_acc);
            end else if (b < ASCII_END) begin
                tally_code_point(CP_W'(b));
            end else if (b < LEAD2_FIRST || b >= LEAD_BAD_FROM) begin
                string_broken = 1'b1;
            end else if (b < LEAD3_FIRST) begin
                cp_acc     = CP_W'(b[4:0]);
                conts_left = PEND_ONE;
            end else if (b < LEAD4_FIRST) begin
                cp_acc     = CP_W'(b[3:0]);
                conts_left = PEND_TWO;
            end else begin
                cp_acc     = CP_W'(b[2:0]);
                conts_left = PEND_THREE;
            end
        end
        if (last) begin
            // A truncated sequence also makes the string invalid
            ok = !string_broken && (conts_left == PEND_NONE);
            due.char_count   = ok ? CHAR_COUNT_W'(chars_seen) : '0;
            due.string_valid = ok;
            string_results_due = {string_results_due, due};
            clear_string_state();
        end
    endfunction

    function automatic void note_failure(input string what, input t_result due);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s: char_count exp %h got %h, string_valid exp %b got %b",
                     $time, what, due.char_count, i_result.char_count,
                     due.string_valid, i_result.string_valid);
        end
    endfunction

    function automatic void check_result();
        t_result due;
        if (string_results_due.size() == 0) begin
            due = '0;
            note_failure("result with no string pending", due);
        end else begin
            due = string_results_due.pop_front();
            if (due.char_count !== i_result.char_count
                || due.string_valid !== i_result.string_valid) begin
                note_failure("result mismatch", due);
            end
        end
    endfunction

    // Sample both channels at each edge; results first, then new bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_string_state();
            string_results_due.delete();
        end else begin
            if (i_result.valid && i_result.ready) check_result();
            if (i_text.valid && i_text.ready)
                decode_byte(i_text.text_byte, i_text.end_of_string);
        end
        o_fail_count  <= fail_count;
        o_outstanding <= string_results_due.size();
    end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the UTF-8 code point counter. Directed strings
// cover the byte classes, the rejected code point ranges, bad leads and
// truncation; random strings follow, mostly well formed with random
// content, plus noise and broken strings. Both channels idle in random
// bursts; ucc_checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    import ucc_pkg::*;

    localparam int COUNT_BITS     = 16;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_BYTES   = 1950;
    localparam int CALM_TAIL      = 300;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_CYCLES     = 10;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;

    // Knobs shared by the stimulus and receiver processes
    bit sender_idling;
    bit receiver_idling;
    bit hold_request;

    logic [BYTE_W-1:0] string_bytes[$];
    int                random_sent;
    int                string_idx;
    int                idle_cycles;

    ucc_text_if   text_ch ();
    ucc_result_if result_ch ();

    utf8_codepoint_counter #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_text   (text_ch),
        .o_result (result_ch)
    );

    ucc_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_text        (text_ch),
        .i_result      (result_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // One byte transaction, with an optional random gap ahead of it
    task automatic put_byte(input logic [BYTE_W-1:0] value, input logic last);
        if (sender_idling && $urandom_range(0, 9) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        text_ch.valid         <= 1'b1;
        text_ch.text_byte     <= value;
        text_ch.end_of_string <= last;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
    endtask

    task automatic send_string();
        int n;
        n = string_bytes.size();
        for (int i = 0; i < n; i++) put_byte(string_bytes[i], i == n - 1);
        string_bytes.delete();
    endtask

    // Stop offering bytes until every queued result has been taken
    task automatic wait_for_results();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Add one byte to the end of the string being built
    function automatic void append_byte(input logic [BYTE_W-1:0] b);
        string_bytes = {string_bytes, b};
    endfunction

    // Continuation byte; now and then with a wrong tag, which goes unchecked
    function automatic logic [BYTE_W-1:0] cont_byte(input logic [5:0] bits6);
        logic [BYTE_W-1:0] b;
        b = {2'b10, bits6};
        if ($urandom_range(0, 7) == 0) b[7:6] = 2'($urandom_range(0, 3));
        return b;
    endfunction

    // Code points on both sides of every class and rejected range
    function automatic logic [CP_W-1:0] edge_code_point(input int idx);
        case (idx)
            0:       return 21'h000000;
            1:       return 21'h00007F;
            2:       return 21'h000080;
            3:       return 21'h0007FF;
            4:       return 21'h000800;
            5:       return 21'h00D7FF;
            6:       return SURR_LO;
            7:       return SURR_HI;
            8:       return 21'h00E000;
            9:       return 21'h00FDCF;
            10:      return NONCHAR_LO;
            11:      return NONCHAR_HI;
            12:      return 21'h00FDF0;
            13:      return 21'h00FFFD;
            14:      return NONCHAR_FFFE;
            15:      return NONCHAR_FFFF;
            16:      return 21'h010000;
            17:      return CP_MAX;
            18:      return 21'h110000;
            default: return 21'h13FFFF;
        endcase
    endfunction

    // Shortest-form encoding; values up to 13FFFF still fit an F4 lead
    function automatic void encode_code_point(input logic [CP_W-1:0] cp);
        if (cp < 21'h80) begin
            append_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            append_byte({3'b110, cp[10:6]});
            append_byte(cont_byte(cp[5:0]));
        end else if (cp < 21'h10000) begin
            append_byte({4'b1110, cp[15:12]});
            append_byte(cont_byte(cp[11:6]));
            append_byte(cont_byte(cp[5:0]));
        end else begin
            append_byte({5'b11110, cp[20:18]});
            append_byte(cont_byte(cp[17:12]));
            append_byte(cont_byte(cp[11:6]));
            append_byte(cont_byte(cp[5:0]));
        end
    endfunction

    // Any lead of a random class with random payload; overlongs included
    function automatic void push_random_code_point();
        int cls;
        cls = $urandom_range(0, 3);
        case (cls)
            0: append_byte(8'($urandom_range(0, ASCII_END - 1)));
            1: append_byte(8'($urandom_range(LEAD2_FIRST, LEAD3_FIRST - 1)));
            2: append_byte(8'($urandom_range(LEAD3_FIRST, LEAD4_FIRST - 1)));
            default: append_byte(8'($urandom_range(LEAD4_FIRST, LEAD_BAD_FROM - 1)));
        endcase
        repeat (cls) append_byte(cont_byte(6'($urandom_range(0, 63))));
    endfunction

    function automatic logic [BYTE_W-1:0] bad_lead();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(ASCII_END, LEAD2_FIRST - 1));
        return 8'($urandom_range(LEAD_BAD_FROM, 8'hFF));
    endfunction

    // Mostly well-formed strings; some noise, truncated or with a bad lead
    function automatic void build_random_string();
        int kind;
        int cps;
        int bad_at;
        int needed;
        logic [BYTE_W-1:0] lead;
        kind = $urandom_range(0, 9);
        if (kind == 7) begin
            repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
        end else begin
            cps    = $urandom_range(1, 12);
            bad_at = (kind == 9) ? $urandom_range(0, cps - 1) : -1;
            for (int i = 0; i < cps; i++) begin
                if (i == bad_at) append_byte(bad_lead());
                if ($urandom_range(0, 7) == 0) encode_code_point(edge_code_point($urandom_range(0, 19)));
                else push_random_code_point();
            end
            if (kind == 8) begin
                // Lead byte whose continuations stop short at the end
                lead = 8'($urandom_range(LEAD2_FIRST, LEAD_BAD_FROM - 1));
                append_byte(lead);
                needed = (lead >= LEAD4_FIRST) ? 3 : (lead >= LEAD3_FIRST) ? 2 : 1;
                repeat ($urandom_range(0, needed - 1))
                    append_byte(cont_byte(6'($urandom_range(0, 63))));
            end
        end
    endfunction

    // Result side: long hold on request, random stall bursts otherwise
    initial begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    initial begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        rst_n                 <= 1'b0;
        text_ch.valid         <= 1'b0;
        text_ch.text_byte     <= '0;
        text_ch.end_of_string <= 1'b0;
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
        hold_request    = 1'b0;
        random_sent     = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every class at its extremes, six characters
        string_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
                         8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // Surrogate
        string_bytes = '{8'hED, 8'hA0, 8'h80};
        send_string();
        // Noncharacter block start
        string_bytes = '{8'hEF, 8'hB7, 8'h90};
        send_string();
        // FFFF
        string_bytes = '{8'hEF, 8'hBF, 8'hBF};
        send_string();
        // Above 10FFFF
        string_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();
        // Bad lead, then a byte that must be ignored
        string_bytes = '{8'h80, 8'h41};
        send_string();
        // Bad leads as one-byte strings
        string_bytes = '{8'hC1};
        send_string();
        string_bytes = '{8'hF5};
        send_string();
        string_bytes = '{8'hFF};
        send_string();
        // Truncated sequence
        string_bytes = '{8'hE2, 8'h82};
        send_string();

        string_idx = 0;
        while (random_sent < RANDOM_BYTES) begin
            if (string_idx == 15) begin
                // Receiver holds off while short strings keep coming
                hold_request = 1'b1;
                repeat (8) begin
                    append_byte(8'($urandom_range(0, 255)));
                    random_sent += string_bytes.size();
                    send_string();
                end
            end
            if (string_idx == 40) wait_for_results();
            // A quiet stretch early on, and a quiet tail
            sender_idling   = !(string_idx >= 25 && string_idx < 35)
                              && (random_sent < RANDOM_BYTES - CALM_TAIL);
            receiver_idling = sender_idling;
            build_random_string();
            random_sent += string_bytes.size();
            send_string();
            string_idx++;
        end

        wait_for_results();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ucc_pkg.sv
rtl/ucc_if.sv
rtl/ucc_decode.sv
rtl/utf8_codepoint_counter.sv
sim/ucc_checker.sv
sim/tb.sv
